/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked on clock and quiet while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every edge
`define ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// consequent holds on the edge after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/fwrw_pkg.sv */
package fwrw_pkg;

   localparam int RULES      = 16;
   localparam int WINDOW     = 100;
   localparam int CELL_SLOTS = 8;
   localparam int CELLS      = (WINDOW + CELL_SLOTS - 1) / CELL_SLOTS;

   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int LIMIT_W    = 8;
   localparam int PKT_W      = 32;
   localparam int HIT_W      = $clog2(WINDOW + 1);
   localparam int POS_W      = $clog2(CELLS * CELL_SLOTS + 1);
   localparam int SLOT_CNT_W = $clog2(CELL_SLOTS + 1);
   localparam int CNT_W      = $clog2(CELLS + 1);
   localparam int RULE_CNT_W = $clog2(RULES + 1);
   localparam int RULE_IDX_W = (RULES > 1) ? $clog2(RULES) : 1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
   localparam logic [1:0] VERDICT_DROP   = 2'd1;
   localparam logic [1:0] VERDICT_LOG    = 2'd2;
   localparam logic [1:0] VERDICT_NONE   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic               addr_on;
      logic [ADDR_W-1:0]  address;
      logic               port_on;
      logic [PORT_W-1:0]  port;
      logic               limit_on;
      logic [LIMIT_W-1:0] limit;
   } rule_type;

   typedef struct packed {
      logic              push;
      logic [ADDR_W-1:0] address;
   } win_cmd_type;

endpackage

/* hw/rtl/firewall_rule_match_rate_window.sv */
// Rule matcher with a per-address rate window. start is taken when busy is low; a load
// (cmd 0) appends a rule if fewer than 16 are held and gives no result; a packet (cmd 1)
// holds busy while the window count ripples down the chain of 13 eight-slot cells, then
// walks the rules, one per cycle, to the first match that is not a log rule, or to the
// no-rule word after at most 16 rules. Result words leave on rsp_valid one per cycle, in
// rule order, one cycle behind the walk, and must be taken when shown: there is no
// back-pressure. The last word of a packet has rsp_last set.
module firewall_rule_match_rate_window import fwrw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   input  logic               req_cmd,
   input  logic [1:0]         req_rule_action,
   input  logic               req_address_check_on,
   input  logic [ADDR_W-1:0]  req_address,
   input  logic               req_port_check_on,
   input  logic [PORT_W-1:0]  req_port_number,
   input  logic               req_limit_check_on,
   input  logic [LIMIT_W-1:0] req_limit_value,
   output logic               busy,
   output logic               rsp_valid,
   output logic [1:0]         rsp_verdict,
   output logic [PKT_W-1:0]   rsp_packet_number,
   output logic               rsp_last
);

   `include "assert_macros.svh"

   state_type           state_ff;
   state_type           state_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic [RULE_CNT_W-1:0] rule_idx_ff;
   logic [RULE_CNT_W-1:0] rule_idx_in;
   logic [RULE_CNT_W-1:0] rule_count_ff;
   rule_type            rules_ff [RULES];
   logic [ADDR_W-1:0]   address_ff;
   logic [PORT_W-1:0]   port_ff;
   logic [PKT_W-1:0]    packet_counter_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_verdict_ff;
   logic [PKT_W-1:0]    rsp_packet_number_ff;
   logic                rsp_last_ff;

   logic                accept;
   logic                eval_go;
   logic                load_go;
   win_cmd_type         win_cmd;
   logic [HIT_W-1:0]    hits;
   rule_type            cur_rule;
   logic                table_end;
   logic                rule_match;
   logic                emit;
   logic [1:0]          verdict_sel;
   logic                last_sel;
   logic                walk_done;

   assign accept  = req_start && !busy;
   assign eval_go = accept && (req_cmd == CMD_EVAL);
   assign load_go = accept && (req_cmd == CMD_LOAD);

   assign win_cmd.push    = eval_go;
   assign win_cmd.address = req_address;

   fwrw_window u_window (
      .clock (clock),
      .reset (reset),
      .cmd   (win_cmd),
      .hits  (hits)
   );

   assign cur_rule  = rules_ff[rule_idx_ff[RULE_IDX_W-1:0]];
   assign table_end = (rule_idx_ff == rule_count_ff);
   assign rule_match = (!cur_rule.addr_on || cur_rule.address == address_ff) &&
                       (!cur_rule.port_on || cur_rule.port == port_ff) &&
                       (!cur_rule.limit_on || 32'(hits) >= 32'(cur_rule.limit));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (eval_go) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      emit        = 1'b0;
      verdict_sel = VERDICT_NONE;
      last_sel    = 1'b1;
      walk_done   = 1'b0;
      cnt_in      = cnt_ff;
      rule_idx_in = rule_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in      = '0;
            rule_idx_in = '0;
         end
         ST_COUNT: begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_WALK: begin
            if (table_end) begin
               emit        = 1'b1;
               verdict_sel = VERDICT_NONE;
               last_sel    = 1'b1;
            end else if (rule_match) begin
               emit        = 1'b1;
               verdict_sel = cur_rule.action;
               last_sel    = (cur_rule.action != VERDICT_LOG);
            end
            walk_done   = emit && last_sel;
            rule_idx_in = rule_idx_ff + RULE_CNT_W'(1);
         end
         default: begin
            cnt_in      = '0;
            rule_idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         cnt_ff            <= '0;
         rule_idx_ff       <= '0;
         rule_count_ff     <= '0;
         packet_counter_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rule_idx_ff  <= rule_idx_in;
         rsp_valid_ff <= emit;
         if (eval_go) begin
            packet_counter_ff <= packet_counter_ff + PKT_W'(1);
         end
         if (load_go && rule_count_ff != RULE_CNT_W'(RULES)) begin
            rule_count_ff <= rule_count_ff + RULE_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eval_go) begin
         address_ff <= req_address;
         port_ff    <= req_port_number;
      end
      if (load_go && rule_count_ff != RULE_CNT_W'(RULES)) begin
         rules_ff[rule_count_ff[RULE_IDX_W-1:0]] <= '{
            action:   req_rule_action,
            addr_on:  req_address_check_on,
            address:  req_address,
            port_on:  req_port_check_on,
            port:     req_port_number,
            limit_on: req_limit_check_on,
            limit:    req_limit_value
         };
      end
      if (emit) begin
         rsp_verdict_ff       <= verdict_sel;
         rsp_packet_number_ff <= packet_counter_ff;
         rsp_last_ff          <= last_sel;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_packet_number = rsp_packet_number_ff;
   assign rsp_last          = rsp_last_ff;

   `ASSERT_ALWAYS(a_rule_count_bound, rule_count_ff <= RULE_CNT_W'(RULES))
   `ASSERT_NEXT(a_word_from_walk, state_ff != ST_WALK, !rsp_valid_ff)
   `ASSERT_NEXT(a_gap_after_last, rsp_valid_ff && rsp_last_ff, !rsp_valid_ff)
   `ASSERT_NEXT(a_walk_in_table, state_ff == ST_WALK && !walk_done,
                rule_idx_ff <= rule_count_ff)

endmodule

/* hw/rtl/fwrw_cell.sv */
module fwrw_cell import fwrw_pkg::*; (
   input  logic              clock,
   input  logic              push,
   input  logic [ADDR_W-1:0] slot_in,
   input  logic [ADDR_W-1:0] probe,
   input  logic [POS_W-1:0]  base,
   input  logic [HIT_W-1:0]  fill,
   input  logic [HIT_W-1:0]  count_in,
   output logic [ADDR_W-1:0] slot_out,
   output logic [HIT_W-1:0]  count_out
);

   logic [ADDR_W-1:0]     slots_ff [CELL_SLOTS];
   logic [HIT_W-1:0]      count_ff;
   logic [HIT_W-1:0]      count_in_sum;
   logic [SLOT_CNT_W-1:0] local_hits;

   // a slot is live when its age is below the fill level
   always_comb begin
      local_hits = '0;
      for (int j = 0; j < CELL_SLOTS; j++) begin
         if ((base + POS_W'(j) < POS_W'(fill)) && (slots_ff[j] == probe)) begin
            local_hits = local_hits + SLOT_CNT_W'(1);
         end
      end
      count_in_sum = count_in + HIT_W'(local_hits);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[0] <= slot_in;
         for (int j = 1; j < CELL_SLOTS; j++) begin
            slots_ff[j] <= slots_ff[j-1];
         end
      end
      count_ff <= count_in_sum;
   end

   assign slot_out  = slots_ff[CELL_SLOTS-1];
   assign count_out = count_ff;

endmodule

/* hw/rtl/fwrw_window.sv */
module fwrw_window import fwrw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  win_cmd_type      cmd,
   output logic [HIT_W-1:0] hits
);

   `include "assert_macros.svh"

   logic [HIT_W-1:0]  fill_ff;
   logic [HIT_W-1:0]  fill_in;
   logic [ADDR_W-1:0] probe_ff;
   logic [ADDR_W-1:0] slot_link  [CELLS+1];
   logic [HIT_W-1:0]  count_link [CELLS+1];

   assign fill_in = (cmd.push && fill_ff != HIT_W'(WINDOW)) ? fill_ff + HIT_W'(1) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         probe_ff <= cmd.address;
      end
   end

   assign slot_link[0]  = cmd.address;
   assign count_link[0] = '0;

   // partial counts ripple one cell per cycle towards the tail
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      fwrw_cell u_cell (
         .clock     (clock),
         .push      (cmd.push),
         .slot_in   (slot_link[k]),
         .probe     (probe_ff),
         .base      (POS_W'(k * CELL_SLOTS)),
         .fill      (fill_ff),
         .count_in  (count_link[k]),
         .slot_out  (slot_link[k+1]),
         .count_out (count_link[k+1])
      );
   end

   assign hits = count_link[CELLS];

   `ASSERT_ALWAYS(a_fill_bound, fill_ff <= HIT_W'(WINDOW))
   `ASSERT_NEXT(a_fill_step, cmd.push && fill_ff != HIT_W'(WINDOW), fill_ff != '0)

endmodule
